FILE: rtl/core/pss_pkg.sv
// shared types and constants of the priority slot scheduler
// no dependencies
`default_nettype none

package pss_pkg;

    localparam int SLOT_W = 4;
    localparam int WORK_W = 16;
    localparam int PRIO_W = 8;

    // function codes of an input item
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef struct packed {
        logic              func;
        logic [SLOT_W-1:0] slot;
        logic [WORK_W-1:0] burst;
        logic [PRIO_W-1:0] prio;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] chosen;
        logic              idle;
        logic [WORK_W-1:0] left_after;
        logic              finished;
    } out_item_t;

    // one table entry as stored in the ram
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [WORK_W-1:0] work;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic write_load;
        logic scan_start;
        logic scan_read;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/pss_stream_if.sv
// valid/ready stream channel carrying one payload item
// payload type is set at instantiation
`default_nettype none

interface pss_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/pss_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module pss_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/pss_ctrl.sv
// sequencer of the priority slot scheduler: load, scan, drain, finish
// depends on pss_pkg
`default_nettype none

module pss_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            in_func,
    output logic                 in_ready,
    input  wire pss_pkg::status_t status,
    output pss_pkg::cmd_t        cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_func == pss_pkg::FUNC_LOAD)
                    begin
                        cmd.write_load = 1'b1;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.scan_read = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last read data is compared here
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/pss_dp.sv
// datapath: slot table ram, valid bits, scan comparator and output register
// depends on pss_pkg and pss_ram
`default_nettype none

module pss_dp #(
    parameter int SLOTS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pss_pkg::in_item_t in_item,
    input  wire pss_pkg::cmd_t     cmd,
    output pss_pkg::status_t       status,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output pss_pkg::out_item_t     out_item
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int EXT_W = 9;

    logic [SLOTS-1:0]           valid_reg;
    logic [IDX_W-1:0]           addr_reg;
    logic                       rd_pending_reg;
    logic                       rd_vbit_reg;
    logic [IDX_W-1:0]           rd_idx_reg;
    logic                       found_reg;
    logic [IDX_W-1:0]           best_idx_reg;
    logic [pss_pkg::WORK_W-1:0] best_work_reg;
    logic [pss_pkg::PRIO_W-1:0] best_prio_reg;
    logic                       out_valid_reg;
    pss_pkg::out_item_t         out_item_reg;

    logic [EXT_W-1:0]           slot_ext;
    logic                       load_in_range;
    logic [IDX_W-1:0]           load_addr;
    pss_pkg::entry_t            rd_entry;
    pss_pkg::entry_t            cand;
    logic                       take;
    logic [pss_pkg::WORK_W-1:0] work_dec;
    logic [EXT_W-1:0]           best_ext;
    logic                       ram_we;
    logic [IDX_W-1:0]           ram_waddr;
    pss_pkg::entry_t            ram_wdata;

    assign slot_ext      = EXT_W'(in_item.slot);
    assign load_in_range = slot_ext < EXT_W'(SLOTS);
    assign load_addr     = slot_ext[IDX_W-1:0];
    assign work_dec      = best_work_reg - pss_pkg::WORK_W'(1);
    assign best_ext      = EXT_W'(best_idx_reg);

    // ram write: a load, or the write-back of the served slot
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = load_addr;
        ram_wdata = '{prio: in_item.prio, work: in_item.burst};
        if (cmd.write_load)
        begin
            ram_we = load_in_range;
        end
        else if (cmd.finish)
        begin
            ram_we    = found_reg;
            ram_waddr = best_idx_reg;
            ram_wdata = '{prio: best_prio_reg, work: work_dec};
        end
    end

    pss_ram #(
        .WIDTH ($bits(pss_pkg::entry_t)),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.scan_read),
        .raddr (addr_reg),
        .rdata (rd_entry)
    );

    // never-loaded slot reads as zero work
    assign cand = rd_vbit_reg ? rd_entry : '0;
    assign take = rd_pending_reg && (cand.work != '0)
                  && (!found_reg || (cand.prio < best_prio_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            addr_reg       <= '0;
            rd_pending_reg <= 1'b0;
            found_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.write_load && load_in_range)
            begin
                valid_reg[load_addr] <= 1'b1;
            end
            if (cmd.scan_start)
            begin
                addr_reg <= '0;
            end
            else if (cmd.scan_read)
            begin
                addr_reg <= addr_reg + IDX_W'(1);
            end
            rd_pending_reg <= cmd.scan_read;
            if (cmd.scan_start)
            begin
                found_reg <= 1'b0;
            end
            else if (take)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_read)
        begin
            rd_idx_reg  <= addr_reg;
            rd_vbit_reg <= valid_reg[addr_reg];
        end
        if (take)
        begin
            best_idx_reg  <= rd_idx_reg;
            best_work_reg <= cand.work;
            best_prio_reg <= cand.prio;
        end
        if (cmd.finish)
        begin
            if (found_reg)
            begin
                out_item_reg.chosen     <= best_ext[pss_pkg::SLOT_W-1:0];
                out_item_reg.idle       <= 1'b0;
                out_item_reg.left_after <= work_dec;
                out_item_reg.finished   <= (work_dec == '0);
            end
            else
            begin
                out_item_reg <= '{chosen: '0, idle: 1'b1, left_after: '0, finished: 1'b0};
            end
        end
    end

    assign status.scan_last    = (addr_reg == IDX_W'(SLOTS - 1));
    assign status.out_free     = !out_valid_reg || out_ready;
    assign out_valid           = out_valid_reg;
    assign out_item            = out_item_reg;

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    // loads and finishes never overlap a pending compare
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_load |-> !rd_pending_reg)
        else $error("load during scan compare");

    a_finish_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !rd_pending_reg)
        else $error("finish before last compare");

    // a finished slot reports zero work and is never idle
    a_finished_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.finished)
        |-> (out_item_reg.left_after == '0 && !out_item_reg.idle))
        else $error("finished result with work left");

endmodule

`default_nettype wire

FILE: rtl/core/priority_slot_scheduler.sv
// top level of the priority slot scheduler
// depends on pss_pkg, pss_stream_if, pss_ctrl, pss_dp (pss_ram)
`default_nettype none

// Preemptive priority scheduler over a table of SLOTS task slots. A load item
// (func = 0) writes one slot's priority and burst; a load to a slot not below
// SLOTS is dropped. A tick item (func = 1) scans the whole table through one
// ram read port and one comparator, one slot per cycle, picks the slot with
// work left and the smallest priority (lowest index on a tie), writes its work
// minus one back and returns one result item. From acceptance to the result
// register a tick goes through the accept in the idle state, the slot reads,
// the last compare and the write-back. The result register lets the next item
// be accepted while a result waits to be taken; a tick only stalls in its
// write-back if the previous result has still not been taken. No result comes
// from a load. The table is cleared at reset by per-slot valid bits, so there
// is no clearing pass. With SLOTS above 16 only the low 4 bits of the slot
// index are shown.

module priority_slot_scheduler #(
    parameter int SLOTS = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pss_stream_if.sink   in_ch,
    pss_stream_if.source out_ch
);

    pss_pkg::cmd_t      cmd;
    pss_pkg::status_t   status;
    pss_pkg::in_item_t  in_item;
    pss_pkg::out_item_t out_item;
    logic               in_ready;
    logic               out_valid;

    assign in_item = in_ch.payload;

    // sequencer: owns the handshake on the input side
    pss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_func  (in_item.func),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // table, scan comparator and result register
    pss_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .status    (status),
        .out_ready (out_ch.ready),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

    assign in_ch.ready    = in_ready;
    assign out_ch.valid   = out_valid;
    assign out_ch.payload = out_item;

endmodule

`default_nettype wire

FILE: tb/priority_slot_scheduler_tb.sv
`timescale 1ns / 100ps
// testbench of the priority slot scheduler: directed table, then random load and tick items
// depends on pss_pkg, pss_stream_if and priority_slot_scheduler

module priority_slot_scheduler_tb;

    localparam int SLOTS        = 16;
    localparam int RANDOM_ITEMS = 450;
    localparam int LIMIT_CYCLES = 200000;
    // accept cycle, one read per slot, last compare, write-back, plus margin
    localparam int DRAIN_CYCLES = SLOTS + 10;
    localparam int LONG_HOLD    = 400;

    // one stimulus row; a pinned row carries its result typed in by hand
    typedef struct {
        pss_pkg::in_item_t  item;
        bit                 pinned;
        pss_pkg::out_item_t res;
    } stim_row_t;

    logic clk;
    logic rst_n;

    pss_stream_if #(.payload_t(pss_pkg::in_item_t))  in_ch ();
    pss_stream_if #(.payload_t(pss_pkg::out_item_t)) out_ch ();

    priority_slot_scheduler #(
        .SLOTS (SLOTS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // shadow copy of the slot table
    logic [pss_pkg::WORK_W-1:0] sched_work [SLOTS];
    logic [pss_pkg::PRIO_W-1:0] sched_prio [SLOTS];

    pss_pkg::out_item_t pending_results [$];  // results still owed by the block, oldest first
    stim_row_t offered_rows [$];              // rows offered but not yet accepted
    stim_row_t dir_rows [$];

    int error_count;
    int results_seen;
    int cycle_count;

    // clock, 10 ns period
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // predicted effect of one item on the table; returns 1 when the item yields a result
    function automatic bit sched_step(input pss_pkg::in_item_t it,
                                      output pss_pkg::out_item_t res);
        int best;
        bit found;
        best  = 0;
        found = 1'b0;
        res   = '0;
        if (it.func == pss_pkg::FUNC_LOAD)
        begin
            // loads with a slot beyond the table are dropped
            if (int'(it.slot) < SLOTS)
            begin
                sched_work[it.slot] = it.burst;
                sched_prio[it.slot] = it.prio;
            end
            return 1'b0;
        end
        // smallest priority among slots with work, strict compare keeps the lowest index
        for (int i = 0; i < SLOTS; i++)
        begin
            if (sched_work[i] != '0 && (!found || sched_prio[i] < sched_prio[best]))
            begin
                best  = i;
                found = 1'b1;
            end
        end
        if (!found)
        begin
            // idle tick: nothing to serve, table untouched
            res.idle = 1'b1;
            return 1'b1;
        end
        sched_work[best] = sched_work[best] - 1'b1;
        res.chosen     = best[pss_pkg::SLOT_W-1:0];
        res.left_after = sched_work[best];
        res.finished   = (sched_work[best] == '0);
        return 1'b1;
    endfunction

    function automatic stim_row_t load_row(input int slot, input int burst, input int prio);
        stim_row_t r;
        r            = '{default: '0};
        r.item.func  = pss_pkg::FUNC_LOAD;
        r.item.slot  = slot[pss_pkg::SLOT_W-1:0];
        r.item.burst = burst[pss_pkg::WORK_W-1:0];
        r.item.prio  = prio[pss_pkg::PRIO_W-1:0];
        return r;
    endfunction

    // tick checked by the predictor; the unused fields carry noise
    function automatic stim_row_t tick_row(input int slot, input int burst, input int prio);
        stim_row_t r;
        r           = load_row(slot, burst, prio);
        r.item.func = pss_pkg::FUNC_TICK;
        return r;
    endfunction

    // tick whose result is written in the table
    function automatic stim_row_t tick_pinned(input int chosen, input bit idle,
                                              input int left_after, input bit finished);
        stim_row_t r;
        r                = tick_row(0, 0, 0);
        r.pinned         = 1'b1;
        r.res.chosen     = chosen[pss_pkg::SLOT_W-1:0];
        r.res.idle       = idle;
        r.res.left_after = left_after[pss_pkg::WORK_W-1:0];
        r.res.finished   = finished;
        return r;
    endfunction

    // random item: loads mostly small bursts with crowded priorities so ties and finishes
    // come often, now and then a zero or a very large burst
    function automatic stim_row_t random_row();
        int pick;
        int burst;
        int prio;
        pick = $urandom_range(0, 9);
        if (pick > 3)
            return tick_row($urandom_range(0, 15), $urandom_range(0, 65535),
                            $urandom_range(0, 255));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            burst = 0;
        else if (pick == 1)
            burst = $urandom_range(0, 65535);
        else
            burst = $urandom_range(1, 4);
        if ($urandom_range(0, 9) < 7)
            prio = $urandom_range(0, 3);
        else
            prio = $urandom_range(0, 255);
        return load_row($urandom_range(0, 15), burst, prio);
    endfunction

    // sender state: items go out in bursts with random gaps between them
    int burst_left;

    task automatic offer(input stim_row_t row);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        offered_rows.push_back(row);
        in_ch.valid   <= 1'b1;
        in_ch.payload <= row.item;
        // wait for the edge at which the item is taken
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // scoreboard: results are checked first, then the accepted item is predicted
    always @(posedge clk)
    begin : scoreboard
        pss_pkg::out_item_t want;
        pss_pkg::out_item_t got;
        pss_pkg::out_item_t pred;
        stim_row_t row;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.payload;
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $error("result item with no expectation: chosen %0d idle %0d",
                           got.chosen, got.idle);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.chosen !== want.chosen)
                    begin
                        $error("chosen: expected %0d, actual %0d", want.chosen, got.chosen);
                        error_count++;
                    end
                    if (got.idle !== want.idle)
                    begin
                        $error("idle: expected %0d, actual %0d", want.idle, got.idle);
                        error_count++;
                    end
                    if (got.left_after !== want.left_after)
                    begin
                        $error("left_after: expected %0d, actual %0d",
                               want.left_after, got.left_after);
                        error_count++;
                    end
                    if (got.finished !== want.finished)
                    begin
                        $error("finished: expected %0d, actual %0d",
                               want.finished, got.finished);
                        error_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                row = offered_rows.pop_front();
                // the predictor always runs so the shadow table stays in step
                if (sched_step(in_ch.payload, pred))
                begin
                    if (row.pinned)
                        pending_results.push_back(row.res);
                    else
                        pending_results.push_back(pred);
                end
            end
        end
    end

    // receiver: stretches of always-ready, coin-flip and one-in-four, plus one long
    // hold-off once enough results have gone by so the block backs up into its input
    initial
    begin : receiver
        int mode;
        int stretch_left;
        int phase;
        int hold_left;
        bit hold_done;
        mode         = 0;
        stretch_left = 0;
        phase        = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (!hold_done && results_seen >= 120)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                if (stretch_left == 0)
                begin
                    mode         = $urandom_range(0, 2);
                    stretch_left = $urandom_range(5, 60);
                    phase        = 0;
                end
                stretch_left--;
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'($urandom_range(0, 1));
                    default: out_ch.ready <= (phase % 4 == 0);
                endcase
                phase++;
            end
        end
    end

    // reset, stimulus and end of run
    initial
    begin
        error_count   = 0;
        results_seen  = 0;
        cycle_count   = 0;
        burst_left    = 0;
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            sched_work[i] = '0;
            sched_prio[i] = '0;
        end

        // empty table after reset, tick fields are don't-care
        dir_rows.push_back(tick_pinned(0, 1'b1, 0, 1'b0));
        dir_rows.push_back(tick_row(15, 65535, 255));
        // top slot, one unit, best priority: served once and finished
        dir_rows.push_back(load_row(15, 1, 0));
        dir_rows.push_back(tick_pinned(15, 1'b0, 0, 1'b1));
        dir_rows.push_back(tick_pinned(0, 1'b1, 0, 1'b0));
        // largest burst at the worst priority
        dir_rows.push_back(load_row(0, 65535, 255));
        dir_rows.push_back(tick_pinned(0, 1'b0, 65534, 1'b0));
        // equal priority, lower index wins
        dir_rows.push_back(load_row(3, 2, 255));
        dir_rows.push_back(tick_row(0, 0, 0));
        // zero burst takes a slot out of the running
        dir_rows.push_back(load_row(0, 0, 0));
        dir_rows.push_back(tick_row(0, 0, 0));
        // reload of a busy slot overwrites work and priority
        dir_rows.push_back(load_row(7, 3, 10));
        dir_rows.push_back(load_row(7, 5, 200));
        dir_rows.push_back(tick_row(0, 0, 0));
        dir_rows.push_back(load_row(9, 1, 200));
        dir_rows.push_back(tick_row(0, 0, 0));
        // alternating bit patterns in burst and priority
        dir_rows.push_back(load_row(1, 16'hAAAA, 8'h55));
        dir_rows.push_back(load_row(14, 16'h5555, 8'hAA));
        dir_rows.push_back(tick_row(10, 16'h5555, 8'hAA));
        dir_rows.push_back(tick_row(5, 16'hAAAA, 8'h55));
        // zero every busy slot again, table back to idle
        dir_rows.push_back(load_row(1, 0, 0));
        dir_rows.push_back(load_row(3, 0, 0));
        dir_rows.push_back(load_row(7, 0, 0));
        dir_rows.push_back(load_row(9, 0, 0));
        dir_rows.push_back(load_row(14, 0, 0));
        dir_rows.push_back(tick_pinned(0, 1'b1, 0, 1'b0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            offer(dir_rows[i]);
        for (int n = 0; n < RANDOM_ITEMS; n++)
            offer(random_row());
        in_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
